// File: src/polyline_length_accumulator_macros.svh
// assertion helpers for the polyline length accumulator
// both expect clk and rst_n in the calling scope
`ifndef POLYLINE_LENGTH_ACCUMULATOR_MACROS_SVH
`define POLYLINE_LENGTH_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define PLA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define PLA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/pla_pkg.sv
package pla_pkg;

    localparam int COORD_WIDTH_DEFAULT = 24;

    localparam int CNT_W       = 10;
    localparam int LEN_W       = 36;
    localparam int FORCE_W     = 24;
    localparam int WORK_W      = 60;
    localparam int LEN_SPLIT   = 18;
    localparam int RAD_MAX_W   = 64;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CNT_W-1:0] MAX_POINTS_RESET = CNT_W'(20);
    localparam logic [FORCE_W-1:0] FORCE_RESET    = '0;

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_POINTS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FORCE      = CFG_INDEX_W'(1);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic sq_x;
        logic sq_y;
        logic root_step;
        logic accum;
        logic mul_lo;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fit;
        logic need_dist;
    } status_t;

endpackage

// File: src/pla_ifs.sv
interface pla_point_if #(
    parameter int COORD_WIDTH = pla_pkg::COORD_WIDTH_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          start_path;

    modport source (output valid, output point_x, output point_y, output start_path,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input start_path,
                  output ready);
endinterface

interface pla_result_if;
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic [pla_pkg::CNT_W-1:0]    points_held;
    logic [pla_pkg::LEN_W-1:0]    path_length;
    logic [pla_pkg::WORK_W-1:0]   work_done;

    modport source (output valid, output accepted, output points_held, output path_length,
                    output work_done, input ready);
    modport sink (input valid, input accepted, input points_held, input path_length,
                  input work_done, output ready);
endinterface

// File: src/pla_datapath.sv
module pla_datapath #(
    parameter int COORD_WIDTH = pla_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [COORD_WIDTH-1:0]       point_x,
    input  logic signed [COORD_WIDTH-1:0]       point_y,
    input  logic                                start_path,
    input  logic                                cfg_we,
    input  logic [pla_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pla_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  pla_pkg::cmd_t                       cmd,
    output pla_pkg::status_t                    status,
    output logic                                accepted,
    output logic [pla_pkg::CNT_W-1:0]           points_held,
    output logic [pla_pkg::LEN_W-1:0]           path_length,
    output logic [pla_pkg::WORK_W-1:0]          work_done
);

    localparam int ABS_W  = COORD_WIDTH + 1;
    localparam int SUMF_W = 2 * COORD_WIDTH + 2;
    localparam int SQ_W   = (SUMF_W > pla_pkg::RAD_MAX_W) ? pla_pkg::RAD_MAX_W : SUMF_W;
    localparam int R_W    = SQ_W / 2;
    localparam int HI_W   = pla_pkg::LEN_W - pla_pkg::LEN_SPLIT;
    localparam int PLO_W  = pla_pkg::LEN_SPLIT + pla_pkg::FORCE_W;
    localparam int PHI_W  = HI_W + pla_pkg::FORCE_W;

    logic [pla_pkg::CNT_W-1:0]    max_points_reg;
    logic [pla_pkg::FORCE_W-1:0]  force_reg;
    logic [COORD_WIDTH-1:0]       prev_x_reg;
    logic [COORD_WIDTH-1:0]       prev_y_reg;
    logic [pla_pkg::CNT_W-1:0]    count_reg;
    logic [pla_pkg::LEN_W-1:0]    len_reg;
    logic [ABS_W-1:0]             abs_x_reg;
    logic [ABS_W-1:0]             abs_y_reg;
    logic [SUMF_W-1:0]            sq_x_reg;
    logic [SQ_W-1:0]              rad_reg;
    logic [R_W+1:0]               rem_reg;
    logic [R_W-1:0]               root_reg;
    logic [PLO_W-1:0]             prod_lo_reg;
    logic                         acc_reg;
    logic                         out_acc_reg;
    logic [pla_pkg::CNT_W-1:0]    out_cnt_reg;
    logic [pla_pkg::LEN_W-1:0]    out_len_reg;
    logic [pla_pkg::WORK_W-1:0]   out_work_reg;

    logic [pla_pkg::CNT_W-1:0]    eff_count;
    logic [ABS_W-1:0]             dx;
    logic [ABS_W-1:0]             dy;
    logic [ABS_W-1:0]             abs_x_next;
    logic [ABS_W-1:0]             abs_y_next;
    logic [SUMF_W-1:0]            sq_y;
    logic [SUMF_W-1:0]            sum_full;
    logic [SQ_W-1:0]              rad_next;
    logic [R_W+1:0]               rem_shift;
    logic [R_W+1:0]               trial;
    logic [pla_pkg::LEN_W:0]      len_sum;
    logic [pla_pkg::LEN_W-1:0]    len_next;
    logic [PHI_W-1:0]             prod_hi;
    logic [pla_pkg::WORK_W-1:0]   work_next;

    // start of a new path counts from zero
    assign eff_count = start_path ? '0 : count_reg;
    assign status.fit       = eff_count < max_points_reg;
    assign status.need_dist = status.fit && (eff_count != '0);

    // sign-extended differences and magnitudes
    assign dx = {point_x[COORD_WIDTH-1], point_x} - {prev_x_reg[COORD_WIDTH-1], prev_x_reg};
    assign dy = {point_y[COORD_WIDTH-1], point_y} - {prev_y_reg[COORD_WIDTH-1], prev_y_reg};
    assign abs_x_next = dx[ABS_W-1] ? (~dx + ABS_W'(1)) : dx;
    assign abs_y_next = dy[ABS_W-1] ? (~dy + ABS_W'(1)) : dy;

    assign sq_y     = abs_y_reg * abs_y_reg;
    assign sum_full = sq_x_reg + sq_y;

    generate
        if (SUMF_W > pla_pkg::RAD_MAX_W) begin : g_sat
            assign rad_next = (|sum_full[SUMF_W-1:pla_pkg::RAD_MAX_W]) ? '1
                                                                      : sum_full[SQ_W-1:0];
        end
        else begin : g_nosat
            assign rad_next = sum_full;
        end
    endgenerate

    // one root bit per step
    assign rem_shift = {rem_reg[R_W-1:0], rad_reg[SQ_W-1:SQ_W-2]};
    assign trial     = {root_reg, 2'b01};

    assign len_sum  = {1'b0, len_reg} + (pla_pkg::LEN_W+1)'(root_reg);
    assign len_next = len_sum[pla_pkg::LEN_W] ? '1 : len_sum[pla_pkg::LEN_W-1:0];

    assign prod_hi   = len_reg[pla_pkg::LEN_W-1:pla_pkg::LEN_SPLIT] * force_reg;
    assign work_next = pla_pkg::WORK_W'(prod_lo_reg)
                     + pla_pkg::WORK_W'({prod_hi, pla_pkg::LEN_SPLIT'(0)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_points_reg <= pla_pkg::MAX_POINTS_RESET;
            force_reg      <= pla_pkg::FORCE_RESET;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            count_reg      <= '0;
            len_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pla_pkg::REG_MAX_POINTS: max_points_reg <= cfg_data[pla_pkg::CNT_W-1:0];
                    pla_pkg::REG_FORCE:      force_reg      <= cfg_data[pla_pkg::FORCE_W-1:0];
                    default:                 ;
                endcase
            end
            if (cmd.load)
            begin
                if (start_path)
                begin
                    len_reg <= '0;
                end
                count_reg <= eff_count;
                if (status.fit)
                begin
                    prev_x_reg <= point_x;
                    prev_y_reg <= point_y;
                    count_reg  <= eff_count + pla_pkg::CNT_W'(1);
                end
            end
            if (cmd.accum)
            begin
                len_reg <= len_next;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            abs_x_reg <= abs_x_next;
            abs_y_reg <= abs_y_next;
            acc_reg   <= status.fit;
        end
        if (cmd.sq_x)
        begin
            sq_x_reg <= abs_x_reg * abs_x_reg;
        end
        if (cmd.sq_y)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[R_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[R_W-2:0], 1'b0};
            end
        end
        if (cmd.mul_lo)
        begin
            prod_lo_reg <= len_reg[pla_pkg::LEN_SPLIT-1:0] * force_reg;
        end
        if (cmd.out_load)
        begin
            out_acc_reg  <= acc_reg;
            out_cnt_reg  <= count_reg;
            out_len_reg  <= len_reg;
            out_work_reg <= work_next;
        end
    end

    assign accepted    = out_acc_reg;
    assign points_held = out_cnt_reg;
    assign path_length = out_len_reg;
    assign work_done   = out_work_reg;

endmodule

// File: src/pla_controller.sv
`include "polyline_length_accumulator_macros.svh"

module pla_controller #(
    parameter int COORD_WIDTH = pla_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  pla_pkg::status_t  status,
    output pla_pkg::cmd_t     cmd
);

    localparam int SUMF_W     = 2 * COORD_WIDTH + 2;
    localparam int SQ_W       = (SUMF_W > pla_pkg::RAD_MAX_W) ? pla_pkg::RAD_MAX_W : SUMF_W;
    localparam int ROOT_ITERS = SQ_W / 2;
    localparam int IT_W       = $clog2(ROOT_ITERS);

    typedef enum logic [2:0] {
        IDLE,
        SQ_X,
        SQ_Y,
        ROOT,
        ACCUM,
        MUL_LO,
        MUL_HI
    } state_t;

    state_t          state_reg;
    logic [IT_W-1:0] iter_reg;
    logic            out_valid_reg;
    logic            out_free;

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == IDLE) && in_valid;
        cmd.sq_x      = (state_reg == SQ_X);
        cmd.sq_y      = (state_reg == SQ_Y);
        cmd.root_step = (state_reg == ROOT);
        cmd.accum     = (state_reg == ACCUM);
        cmd.mul_lo    = (state_reg == MUL_LO);
        cmd.out_load  = (state_reg == MUL_HI) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= status.need_dist ? SQ_X : MUL_LO;
                    end
                end
                SQ_X:   state_reg <= SQ_Y;
                SQ_Y:
                begin
                    iter_reg  <= IT_W'(ROOT_ITERS - 1);
                    state_reg <= ROOT;
                end
                ROOT:
                begin
                    if (iter_reg == '0)
                    begin
                        state_reg <= ACCUM;
                    end
                    else
                    begin
                        iter_reg <= iter_reg - IT_W'(1);
                    end
                end
                ACCUM:  state_reg <= MUL_LO;
                MUL_LO: state_reg <= MUL_HI;
                MUL_HI:
                begin
                    if (out_free)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    `PLA_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready)
    `PLA_ASSERT_NEXT(a_dist_path, in_valid && in_ready && status.need_dist, state_reg == SQ_X)
    `PLA_ASSERT_NEXT(a_short_path, in_valid && in_ready && !status.need_dist, state_reg == MUL_LO)
    `PLA_ASSERT_IMPL(a_root_done, state_reg == ACCUM, $past(state_reg) == ROOT && $past(iter_reg) == '0)

endmodule

// File: src/polyline_length_accumulator.sv
// a point that adds a distance goes through the squares, the one-bit-per-cycle square root of the
// squared distance, the accumulate and the two-part force multiply before its result is registered;
// first, rejected or restarted points skip the squares, the root and the accumulate
// points are taken one at a time; a waiting result holds the next point at its last step
// reset: asynchronous, active low; max_points returns to 20, force to 0, the path is cleared
`include "polyline_length_accumulator_macros.svh"

module polyline_length_accumulator #(
    parameter int COORD_WIDTH = pla_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pla_point_if.sink                        points,
    pla_result_if.source                     results,
    input  logic                             cfg_we,
    input  logic [pla_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pla_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // command and status between the sequencer and the datapath
    pla_pkg::cmd_t    cmd;
    pla_pkg::status_t status;

    // sequencer: intake, square, root iterations, accumulate, two-part force multiply,
    // then the result register which frees the next transfer
    pla_controller #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (points.valid),
        .in_ready  (points.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: previous point, count, running length, config and the result register
    pla_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_x     (points.point_x),
        .point_y     (points.point_y),
        .start_path  (points.start_path),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .accepted    (results.accepted),
        .points_held (results.points_held),
        .path_length (results.path_length),
        .work_done   (results.work_done)
    );

    // a point is never taken in the cycle the result register loads
    `PLA_ASSERT_IMPL(a_intake_idle, points.valid && points.ready, !(cmd.out_load))

endmodule
